### src/dps_pkg.sv
package dps_pkg;

    localparam int TOP_COUNT  = 4;
    localparam int ATTR_COUNT = 6;

    localparam int ID_W     = 10;
    localparam int ATTR_W   = 8;
    localparam int WEIGHT_W = 9;
    localparam int PROD_W   = WEIGHT_W + ATTR_W;
    localparam int SUM_W    = PROD_W + 3;
    localparam int SCORE_W  = 18;
    localparam int RANK_W   = 2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;
    localparam logic [CFG_IDX_W-1:0] CFG_ADMIRER = 3'd6;

    // front-to-back queue
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    // output slot buffer
    localparam int OUT_CNT_W = 3;

    typedef struct packed {
        logic [ID_W-1:0]          item_id;
        logic signed [ATTR_W-1:0] attr_0;
        logic signed [ATTR_W-1:0] attr_1;
        logic signed [ATTR_W-1:0] attr_2;
        logic signed [ATTR_W-1:0] attr_3;
        logic signed [ATTR_W-1:0] attr_4;
        logic signed [ATTR_W-1:0] attr_5;
        logic                     last_item;
    } t_item;

    typedef struct packed {
        logic [RANK_W-1:0]  rank;
        logic [ID_W-1:0]    candidate_id;
        logic [SCORE_W-1:0] score;
        logic               slot_valid;
        logic               last_slot;
    } t_res;

    // classified candidate handed from front to back
    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic [ID_W-1:0]    id;
        logic               eligible;
        logic               last;
    } t_cand;

    typedef struct packed {
        logic [Q_CNT_W-1:0] count;
        logic               not_empty;
    } t_q_status;

endpackage

### src/dps_front.sv
module dps_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [dps_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [dps_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_push,
    input  dps_pkg::t_item                 i_item,
    input  dps_pkg::t_q_status             i_q_status,
    output logic                           o_full,
    output logic                           o_cand_valid,
    output dps_pkg::t_cand                 o_cand
);
    import dps_pkg::*;

    logic signed [WEIGHT_W-1:0] r_weight [ATTR_COUNT];
    logic [ID_W-1:0]            r_admirer;

    logic signed [ATTR_W-1:0]   attr   [ATTR_COUNT];
    logic signed [PROD_W-1:0]   n_prod [ATTR_COUNT];
    logic signed [PROD_W-1:0]   r_prod [ATTR_COUNT];
    logic                       r_s1_valid;
    logic [ID_W-1:0]            r_s1_id;
    logic                       r_s1_last;
    logic                       r_s1_self;
    logic signed [SUM_W-1:0]    sum;
    logic                       accept;
    logic [Q_CNT_W-1:0]         credit_used;

    assign attr[0] = i_item.attr_0;
    assign attr[1] = i_item.attr_1;
    assign attr[2] = i_item.attr_2;
    assign attr[3] = i_item.attr_3;
    assign attr[4] = i_item.attr_4;
    assign attr[5] = i_item.attr_5;

    // queue slots taken or promised to the item in the multiply stage
    assign credit_used = i_q_status.count + Q_CNT_W'(r_s1_valid);
    assign o_full      = credit_used >= Q_CNT_W'(Q_DEPTH);
    assign accept      = i_push && !o_full;

    always_comb begin
        for (int k = 0; k < ATTR_COUNT; k++) begin
            n_prod[k] = PROD_W'(r_weight[k]) * PROD_W'(attr[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < ATTR_COUNT; k++) begin
                r_weight[k] <= '0;
            end
            r_admirer  <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx < CFG_IDX_W'(ATTR_COUNT)) begin
                    r_weight[i_cfg_idx] <= i_cfg_data[WEIGHT_W-1:0];
                end else if (i_cfg_idx == CFG_ADMIRER) begin
                    r_admirer <= i_cfg_data[ID_W-1:0];
                end
            end
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_prod    <= n_prod;
            r_s1_id   <= i_item.item_id;
            r_s1_last <= i_item.last_item;
            r_s1_self <= i_item.item_id == r_admirer;
        end
    end

    always_comb begin
        sum = '0;
        for (int k = 0; k < ATTR_COUNT; k++) begin
            sum = sum + SUM_W'(r_prod[k]);
        end
    end

    // nonnegative sums never exceed the score range, so no saturation
    assign o_cand_valid   = r_s1_valid;
    assign o_cand.score    = sum[SCORE_W-1:0];
    assign o_cand.id       = r_s1_id;
    assign o_cand.eligible = !r_s1_self && !sum[SUM_W-1];
    assign o_cand.last     = r_s1_last;

endmodule

### src/dps_queue.sv
module dps_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_wr,
    input  dps_pkg::t_cand     i_wr_data,
    input  logic               i_rd,
    output dps_pkg::t_cand     o_head,
    output dps_pkg::t_q_status o_status
);
    import dps_pkg::*;

    t_cand              r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + Q_CNT_W'(i_wr) - Q_CNT_W'(i_rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    assign o_head             = r_mem[r_rd_ptr];
    assign o_status.count     = r_count;
    assign o_status.not_empty = r_count != '0;

endmodule

### src/dps_back.sv
module dps_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_not_empty,
    input  dps_pkg::t_cand i_head,
    output logic           o_q_pop,
    input  logic           i_pop,
    output logic           o_empty,
    output dps_pkg::t_res  o_res
);
    import dps_pkg::*;

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic [ID_W-1:0]    id;
        logic               valid;
    } t_slot;

    t_slot                r_list [TOP_COUNT];
    t_slot                n_list [TOP_COUNT];
    logic [TOP_COUNT-1:0] beats;
    t_slot                cand_slot;

    t_slot                r_out [TOP_COUNT];
    logic [OUT_CNT_W-1:0] r_out_cnt;
    logic [RANK_W-1:0]    r_out_idx;
    logic                 out_pop;
    logic                 load_ok;
    logic                 do_insert;
    logic                 do_load;

    assign out_pop   = i_pop && !o_empty;
    // the buffer can take a new round once its final slot leaves
    assign load_ok   = (r_out_cnt == '0) || (r_out_cnt == OUT_CNT_W'(1) && out_pop);
    assign o_q_pop   = i_q_not_empty && (!i_head.last || load_ok);
    assign do_insert = o_q_pop && i_head.eligible;
    assign do_load   = o_q_pop && i_head.last;

    assign cand_slot.score = i_head.score;
    assign cand_slot.id    = i_head.id;
    assign cand_slot.valid = 1'b1;

    // valid slots come first in descending order, so beats is a thermometer
    always_comb begin
        for (int k = 0; k < TOP_COUNT; k++) begin
            beats[k] = !r_list[k].valid || (r_list[k].score < i_head.score);
        end
        for (int k = 0; k < TOP_COUNT; k++) begin
            if (!do_insert) begin
                n_list[k] = r_list[k];
            end else if (k > 0 && beats[(k > 0) ? k - 1 : 0]) begin
                n_list[k] = r_list[(k > 0) ? k - 1 : 0];
            end else if (beats[k]) begin
                n_list[k] = cand_slot;
            end else begin
                n_list[k] = r_list[k];
            end
        end
    end

    // slot data needs no reset; only the valid bits are cleared
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < TOP_COUNT; k++) begin
            r_list[k].score <= n_list[k].score;
            r_list[k].id    <= n_list[k].id;
        end
        if (!i_rst_n) begin
            for (int k = 0; k < TOP_COUNT; k++) begin
                r_list[k].valid <= 1'b0;
            end
            r_out_cnt <= '0;
            r_out_idx <= '0;
        end else begin
            for (int k = 0; k < TOP_COUNT; k++) begin
                r_list[k].valid <= do_load ? 1'b0 : n_list[k].valid;
            end
            if (do_load) begin
                r_out_cnt <= OUT_CNT_W'(TOP_COUNT);
                r_out_idx <= '0;
            end else if (out_pop) begin
                r_out_cnt <= r_out_cnt - 1'b1;
                r_out_idx <= r_out_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_load) begin
            for (int k = 0; k < TOP_COUNT; k++) begin
                r_out[k].valid <= n_list[k].valid;
                r_out[k].score <= n_list[k].valid ? n_list[k].score : '0;
                r_out[k].id    <= n_list[k].valid ? n_list[k].id : '0;
            end
        end
    end

    assign o_empty            = r_out_cnt == '0;
    assign o_res.rank         = r_out_idx;
    assign o_res.candidate_id = r_out[r_out_idx].id;
    assign o_res.score        = r_out[r_out_idx].score;
    assign o_res.slot_valid   = r_out[r_out_idx].valid;
    assign o_res.last_slot    = r_out_idx == RANK_W'(TOP_COUNT - 1);

endmodule

### src/dot_product_top_k_select.sv
// Weighted-score top-4 selection for one admirer.
//
// Configuration: write i_cfg_data at i_cfg_idx with i_cfg_we, only while the
// block is idle. Indexes 0..5 load the signed 9-bit weights, index 6 the
// admirer id; other indexes are ignored. Weights and admirer id reset to zero.
// Input: an item (entity id, six signed attributes, last flag) is taken on a
// clock edge with i_push high and o_full low. One item per cycle is sustained
// until o_full rises. Items with the admirer id or a negative score are dropped.
// Output: an item marked last releases four ranked slots, rank 0 first, each
// popped with i_pop while o_empty is low. The first slot is visible after the
// last item passes the multiply stage register and the queue and is loaded
// into the output buffer (the top-4 insert and the output load share one edge).
// Throughput is one item per cycle while o_full is low; a round also needs
// four pops. If the receiver stalls, the four slots wait in the output
// buffer while scoring continues; the next last item waits in the four-entry
// queue until the final slot leaves, and o_full rises once that queue fills.
// Reset (synchronous, active low) empties the queue, list and output buffer.
module dot_product_top_k_select (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [dps_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [dps_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_push,
    output logic                           o_full,
    input  dps_pkg::t_item                 i_item,
    output logic                           o_empty,
    input  logic                           i_pop,
    output dps_pkg::t_res                  o_res
);
    import dps_pkg::*;

    logic      cand_valid;
    t_cand     cand;
    t_cand     q_head;
    t_q_status q_status;
    logic      q_pop;

    // front: config registers, six multipliers, adder and classification
    dps_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_push       (i_push),
        .i_item       (i_item),
        .i_q_status   (q_status),
        .o_full       (o_full),
        .o_cand_valid (cand_valid),
        .o_cand       (cand)
    );

    // decoupling queue; front only pushes when it holds a credit
    dps_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (cand_valid),
        .i_wr_data (cand),
        .i_rd      (q_pop),
        .o_head    (q_head),
        .o_status  (q_status)
    );

    // back: top-4 insert and ranked output buffer
    dps_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_not_empty (q_status.not_empty),
        .i_head        (q_head),
        .o_q_pop       (q_pop),
        .i_pop         (i_pop),
        .o_empty       (o_empty),
        .o_res         (o_res)
    );

endmodule

### src/dps_checker.sv
module dps_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_pop,
    input  logic          o_empty,
    input  dps_pkg::t_res o_res
);
    import dps_pkg::*;

    // a round is four slots in a row: no gap before the final one
    a_round_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pop && !o_empty && !o_res.last_slot) |=> !o_empty)
        else $error("result queue ran dry inside a round");

    a_rank_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pop && !o_empty && !o_res.last_slot) |=>
        (o_res.rank == RANK_W'($past(o_res.rank) + 1'b1)))
        else $error("rank did not advance by one");

    a_last_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> (o_res.last_slot == (o_res.rank == RANK_W'(TOP_COUNT - 1))))
        else $error("last_slot does not match final rank");

    a_empty_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !o_res.slot_valid) |->
        (o_res.candidate_id == '0 && o_res.score == '0))
        else $error("empty slot carries data");

    a_empty_slots_trail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pop && !o_empty && !o_res.slot_valid && !o_res.last_slot) |=>
        !o_res.slot_valid)
        else $error("valid slot after an empty one");

endmodule

bind dot_product_top_k_select dps_checker u_dps_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_pop   (i_pop),
    .o_empty (o_empty),
    .o_res   (o_res)
);
